[hw/rtl/tree_distance_binary_lifting_assert.svh]
// assertion macros for the tree distance block
`ifndef TREE_DISTANCE_BINARY_LIFTING_ASSERT_SVH
`define TREE_DISTANCE_BINARY_LIFTING_ASSERT_SVH

// same-cycle implication
`define TDBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tdbl_pkg.sv]
// shared widths, codes and defaults for the tree distance block
`timescale 1ns / 1ps

package tdbl_pkg;

    localparam int NodesDef  = 65536;
    localparam int LevelsDef = 16;

    localparam int NODE_W  = 16;
    localparam int DEPTH_W = 16;
    localparam int DIST_W  = 17;
    localparam int FUNC_W  = 1;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

endpackage

[hw/rtl/tdbl_if.sv]
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface tdbl_in_if import tdbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] other_node;

    modport source (output valid, output func, output node, output other_node, input ready);
    modport sink   (input valid, input func, input node, input other_node, output ready);
endinterface

interface tdbl_out_if import tdbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

[hw/rtl/tree_distance_binary_lifting.sv]
// tree distance engine: binary-lifting ancestor table with lca distance queries
//
// Holds a rooted tree (node 0 is the root) in two synchronous registered-read
// memories: an ancestor table of NODES x LEVELS entries (row n, level k is the
// 2^k-th ancestor of n) and a depth table of NODES entries. An add item
// (func = 0) stores node under parent other_node; parents must be added before
// their children, and adding node 0 is ignored. A query item (func = 1) returns
// the edge count of the path between node and other_node, found through their
// lowest common ancestor. Node numbers are taken modulo NODES. Only the root
// has a defined reset value; it is served by logic (root reads return zero), so
// there is no clearing pass and the block takes items right after reset; nodes
// never added must not be queried or used as parents.
// Sequence, from the item transfer until the block takes the next item: an add
// reads the parent depth, writes the depth and the level 0 ancestor, then reads
// and writes the ancestor memory once per further level; an add of node 0 goes
// straight back to idle. A query reads both depths, lifts the deeper node to
// equal depth (a dependent ancestor read and depth read per level) and, unless
// that already meets the other node, lifts both with one dual-port ancestor read
// per level. When NODES is not a power of two and below 65536, the modulo
// reduction adds a reciprocal multiply step, then a multiply and subtract step.
// A finished distance sits in an output register, so the next item can be
// taken while the result still waits for its transfer; a query whose distance
// is ready stalls in its last cycle while an earlier distance still waits.
`timescale 1ns / 1ps

module tree_distance_binary_lifting
    import tdbl_pkg::*;
#(
    parameter int NODES  = NodesDef,
    parameter int LEVELS = LevelsDef
) (
    input  logic       clk,
    input  logic       rst_n,
    tdbl_in_if.sink    item,
    tdbl_out_if.source result
);

    // node index and level index widths
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // remainder step only when the modulo is not a plain truncation
    localparam bit          MOD_NEEDED = (NODES < 65536) && ((NODES & (NODES - 1)) != 0);
    // reciprocal of NODES rounded up, exact quotient for 16-bit node numbers
    localparam logic [31:0] RECIP      = 32'((64'd1 << 32) / 64'(NODES) + 64'd1);
    localparam logic [NODE_W-1:0] NODES_LO = NODE_W'(NODES);
    localparam logic [LW-1:0] LVL_TOP  = LW'(LEVELS - 1);
    localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 2);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_START,
        S_ADD_DEP,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_DX,
        S_Q_DY,
        S_L1_RD,
        S_L1_CMP,
        S_L2,
        S_C_RD,
        S_FIN
    } state_t;

    // control and working registers
    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [NODE_W-1:0]   xr_reg, xr_next;
    logic [NODE_W-1:0]   yr_reg, yr_next;
    logic [31:0]         div_reg, div_next;
    logic [3:0]          mcnt_reg, mcnt_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [NW-1:0]       m_reg, m_next;
    logic [NW-1:0]       a_reg, a_next;
    logic [NW-1:0]       b_reg, b_next;
    logic [NW-1:0]       up_reg, up_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic [DEPTH_W-1:0]  dx_reg, dx_next;
    logic [DEPTH_W-1:0]  dy_reg, dy_next;
    logic [DEPTH_W-1:0]  db_reg, db_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   distance_reg, distance_next;

    // memory ports
    logic                anc_re;
    logic [NW-1:0]       anc_ran, anc_rbn;
    logic [LW-1:0]       anc_ral, anc_rbl;
    logic                anc_we;
    logic [NW-1:0]       anc_wn;
    logic [LW-1:0]       anc_wl;
    logic [NODE_W-1:0]   anc_wd;
    logic                dep_re;
    logic [NW-1:0]       dep_ra;
    logic                dep_we;
    logic [NW-1:0]       dep_wa;
    logic [DEPTH_W-1:0]  dep_wd;

    logic [NODE_W-1:0]   anc_mem [NODES][LEVELS];
    logic [DEPTH_W-1:0]  dep_mem [NODES];
    logic [NODE_W-1:0]   anc_qa_mem_reg, anc_qb_mem_reg;
    logic                anc_qa_root_reg, anc_qb_root_reg;
    logic [DEPTH_W-1:0]  dep_q_mem_reg;
    logic                dep_q_root_reg;

    // read data with the root row and root depth forced to zero
    logic [NODE_W-1:0]   anc_qa, anc_qb;
    logic [DEPTH_W-1:0]  dep_q;

    logic [NW-1:0]       x_idx, y_idx;
    logic [NW-1:0]       a_new, b_new;
    logic [NW-1:0]       ua, ub;
    logic                ab_differ;
    logic [DIST_W-1:0]   dsum, dtwice, dist_val;

    // modulo: quotient by reciprocal, then remainder by multiply and subtract
    logic [47:0]         xprod, yprod;
    logic [31:0]         xqn, yqn;

    assign anc_qa = anc_qa_root_reg ? '0 : anc_qa_mem_reg;
    assign anc_qb = anc_qb_root_reg ? '0 : anc_qb_mem_reg;
    assign dep_q  = dep_q_root_reg ? '0 : dep_q_mem_reg;

    assign x_idx = NW'(xr_reg);
    assign y_idx = NW'(yr_reg);
    assign ua    = NW'(anc_qa);
    assign ub    = NW'(anc_qb);
    assign ab_differ = (anc_qa != anc_qb);

    assign xprod = {32'd0, xr_reg} * {16'd0, RECIP};
    assign yprod = {32'd0, yr_reg} * {16'd0, RECIP};
    assign xqn   = {16'd0, div_reg[NODE_W-1:0]} * {16'd0, NODES_LO};
    assign yqn   = {16'd0, div_reg[2*NODE_W-1:NODE_W]} * {16'd0, NODES_LO};

    // depth(x) + depth(y) - 2 * depth(lca), floored at zero for odd trees
    assign dsum     = {1'b0, dx_reg} + {1'b0, dy_reg};
    assign dtwice   = {dep_q, 1'b0};
    assign dist_val = (dsum >= dtwice) ? (dsum - dtwice) : '0;

    assign item.ready      = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.distance = distance_reg;

    // ancestor table: one write port, two read ports, registered reads
    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_wn][anc_wl] <= anc_wd;
        end
        if (anc_re)
        begin
            anc_qa_mem_reg  <= anc_mem[anc_ran][anc_ral];
            anc_qb_mem_reg  <= anc_mem[anc_rbn][anc_rbl];
            anc_qa_root_reg <= (anc_ran == '0);
            anc_qb_root_reg <= (anc_rbn == '0);
        end
    end

    // depth table: one write port, one read port, registered read
    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_wa] <= dep_wd;
        end
        if (dep_re)
        begin
            dep_q_mem_reg  <= dep_mem[dep_ra];
            dep_q_root_reg <= (dep_ra == '0);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        xr_next        = xr_reg;
        yr_next        = yr_reg;
        div_next       = div_reg;
        mcnt_next      = mcnt_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        up_next        = up_reg;
        lvl_next       = lvl_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        db_next        = db_reg;
        out_valid_next = out_valid_reg;
        distance_next  = distance_reg;

        anc_re  = 1'b0;
        anc_ran = '0;
        anc_ral = '0;
        anc_rbn = '0;
        anc_rbl = '0;
        anc_we  = 1'b0;
        anc_wn  = '0;
        anc_wl  = '0;
        anc_wd  = '0;
        dep_re  = 1'b0;
        dep_ra  = '0;
        dep_we  = 1'b0;
        dep_wa  = '0;
        dep_wd  = '0;
        a_new   = a_reg;
        b_new   = b_reg;

        // result transfer frees the output register
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    func_next  = item.func;
                    xr_next    = item.node;
                    yr_next    = item.other_node;
                    mcnt_next  = 4'd1;
                    state_next = MOD_NEEDED ? S_MOD : S_START;
                end
            end

            // both quotients first, then both remainders
            S_MOD:
            begin
                if (mcnt_reg != 4'd0)
                begin
                    div_next  = {yprod[47:32], xprod[47:32]};
                    mcnt_next = mcnt_reg - 4'd1;
                end
                else
                begin
                    xr_next    = xr_reg - xqn[NODE_W-1:0];
                    yr_next    = yr_reg - yqn[NODE_W-1:0];
                    state_next = S_START;
                end
            end

            S_START:
            begin
                n_next = x_idx;
                m_next = y_idx;
                if (func_reg == FUNC_ADD)
                begin
                    if (x_idx == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dep_re     = 1'b1;
                        dep_ra     = y_idx;
                        state_next = S_ADD_DEP;
                    end
                end
                else
                begin
                    dep_re     = 1'b1;
                    dep_ra     = x_idx;
                    state_next = S_Q_DX;
                end
            end

            // parent depth is here: store depth and the level 0 ancestor
            S_ADD_DEP:
            begin
                dep_we   = 1'b1;
                dep_wa   = n_reg;
                dep_wd   = (dep_q == DEPTH_MAX) ? dep_q : dep_q + 1'b1;
                anc_we   = 1'b1;
                anc_wn   = n_reg;
                anc_wl   = '0;
                anc_wd   = NODE_W'(m_reg);
                a_next   = m_reg;
                lvl_next = '0;
                state_next = (LEVELS == 1) ? S_IDLE : S_ADD_RD;
            end

            S_ADD_RD:
            begin
                anc_re     = 1'b1;
                anc_ran    = a_reg;
                anc_ral    = lvl_reg;
                state_next = S_ADD_WR;
            end

            // ancestor of ancestor becomes the next level of the new row
            S_ADD_WR:
            begin
                anc_we = 1'b1;
                anc_wn = n_reg;
                anc_wl = lvl_reg + 1'b1;
                anc_wd = anc_qa;
                a_next = ua;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end

            S_Q_DX:
            begin
                dx_next    = dep_q;
                dep_re     = 1'b1;
                dep_ra     = m_reg;
                state_next = S_Q_DY;
            end

            // pick the deeper node to lift
            S_Q_DY:
            begin
                dy_next = dep_q;
                if (dx_reg < dep_q)
                begin
                    a_new   = m_reg;
                    b_new   = n_reg;
                    db_next = dx_reg;
                end
                else
                begin
                    a_new   = n_reg;
                    b_new   = m_reg;
                    db_next = dep_q;
                end
                a_next     = a_new;
                b_next     = b_new;
                lvl_next   = LVL_TOP;
                anc_re     = 1'b1;
                anc_ran    = a_new;
                anc_ral    = LVL_TOP;
                state_next = S_L1_RD;
            end

            S_L1_RD:
            begin
                up_next    = ua;
                dep_re     = 1'b1;
                dep_ra     = ua;
                state_next = S_L1_CMP;
            end

            // take the jump if it does not go above the other node's depth
            S_L1_CMP:
            begin
                a_new  = (dep_q >= db_reg) ? up_reg : a_reg;
                a_next = a_new;
                if (lvl_reg != '0)
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    anc_re     = 1'b1;
                    anc_ran    = a_new;
                    anc_ral    = lvl_reg - 1'b1;
                    state_next = S_L1_RD;
                end
                else if (a_new == b_reg)
                begin
                    dep_re     = 1'b1;
                    dep_ra     = a_new;
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    anc_re     = 1'b1;
                    anc_ran    = a_new;
                    anc_ral    = LVL_TOP;
                    anc_rbn    = b_reg;
                    anc_rbl    = LVL_TOP;
                    state_next = S_L2;
                end
            end

            // lift both while their ancestors differ
            S_L2:
            begin
                if (lvl_reg != '0)
                begin
                    a_new      = ab_differ ? ua : a_reg;
                    b_new      = ab_differ ? ub : b_reg;
                    a_next     = a_new;
                    b_next     = b_new;
                    lvl_next   = lvl_reg - 1'b1;
                    anc_re     = 1'b1;
                    anc_ran    = a_new;
                    anc_ral    = lvl_reg - 1'b1;
                    anc_rbn    = b_new;
                    anc_rbl    = lvl_reg - 1'b1;
                end
                else if (ab_differ)
                begin
                    anc_re     = 1'b1;
                    anc_ran    = ua;
                    anc_ral    = '0;
                    state_next = S_C_RD;
                end
                else
                begin
                    dep_re     = 1'b1;
                    dep_ra     = ua;
                    state_next = S_FIN;
                end
            end

            S_C_RD:
            begin
                dep_re     = 1'b1;
                dep_ra     = ua;
                state_next = S_FIN;
            end

            // lca depth is here; wait for a free output register
            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = dist_val;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FUNC_ADD;
            xr_reg        <= '0;
            yr_reg        <= '0;
            div_reg       <= '0;
            mcnt_reg      <= '0;
            n_reg         <= '0;
            m_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            up_reg        <= '0;
            lvl_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            db_reg        <= '0;
            out_valid_reg <= 1'b0;
            distance_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            xr_reg        <= xr_next;
            yr_reg        <= yr_next;
            div_reg       <= div_next;
            mcnt_reg      <= mcnt_next;
            n_reg         <= n_next;
            m_reg         <= m_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            up_reg        <= up_next;
            lvl_reg       <= lvl_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            db_reg        <= db_next;
            out_valid_reg <= out_valid_next;
            distance_reg  <= distance_next;
        end
    end

endmodule

[hw/rtl/tdbl_chk.sv]
// port-level checker for the tree distance block, bound to the top level
`timescale 1ns / 1ps

`include "tree_distance_binary_lifting_assert.svh"

module tdbl_chk
    import tdbl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic [FUNC_W-1:0] item_func,
    input logic              result_valid,
    input logic              result_ready,
    input logic [DIST_W-1:0] result_distance
);

    // queries taken whose distance has not been transferred yet
    logic [1:0] pend_reg, pend_next;
    logic       q_xfer, r_xfer;

    assign q_xfer = item_valid && item_ready && (item_func == FUNC_QUERY);
    assign r_xfer = result_valid && result_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (q_xfer && !r_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (r_xfer && !q_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `TDBL_ASSERT_IMP(a_no_stray_result, clk, rst_n, result_valid, pend_reg != 2'd0, "result without a pending query")
    `TDBL_ASSERT_IMP(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= 2'd2, "more than two queries in flight")
    `TDBL_ASSERT_NXT(a_busy_after_take, clk, rst_n, item_valid && item_ready, !item_ready, "item taken while still working")
    `TDBL_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_distance), "stalled result changed")

endmodule

bind tree_distance_binary_lifting tdbl_chk u_tdbl_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_func       (item.func),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_distance (result.distance)
);

[sim/tree_distance_binary_lifting_tb.sv]
// testbench for the tree distance block: random tree building and path length checks
`timescale 1ns / 1ps

module tree_distance_binary_lifting_tb;
    import tdbl_pkg::*;

    // a quiet stretch this long means the block has hung
    // worst legal gap: long receiver hold plus one query
    localparam int unsigned QUIET_LIMIT  = 3000;
    // receiver hold-off that makes the block back up into its input
    localparam int unsigned LONG_HOLD    = 500;
    // cycles to keep watching after the last expected distance
    localparam int unsigned DRAIN_CYCLES = 120;
    // random items wanted after the directed part
    localparam int unsigned RANDOM_ITEMS = 1375;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] other_node;
    } tree_op_t;

    logic clk = 1'b0;
    logic rst_n;

    tdbl_in_if  item_ch ();
    tdbl_out_if result_ch ();

    tree_distance_binary_lifting uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: our own copy of the lifting table and depths
    // bit arrays start at zero, which matches the root after reset
    // ---------------------------------------------------------------
    bit [NODE_W-1:0]  lift_tab [0:NodesDef-1][0:LevelsDef-1];
    bit [DEPTH_W-1:0] depth_tab [0:NodesDef-1];

    // distances still owed by the block, oldest first
    bit [DIST_W-1:0] distance_due [$];

    // stimulus not yet offered
    tree_op_t pending [$];

    // stimulus-side view of the tree, used only to keep reads defined
    bit          in_tree [0:NodesDef-1];
    int unsigned members [$];

    int unsigned total_items  = 0;
    int unsigned items_taken  = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    bit          long_hold_done = 1'b0;

    // node numbers fit the default table exactly, so no modulo is needed

    // store a node under its parent and fill its row level by level,
    // reading the row in place so inconsistent trees behave like the block
    function automatic void graft_node(bit [NODE_W-1:0] n, bit [NODE_W-1:0] p);
        int unsigned d;
        bit [NODE_W-1:0] mid;
        if (n == 0)
            return;
        d = int'(depth_tab[p]) + 1;
        if (d > 65535)
            d = 65535;
        depth_tab[n] = d[DEPTH_W-1:0];
        lift_tab[n][0] = p;
        for (int k = 1; k < LevelsDef; k++)
        begin
            mid = lift_tab[n][k-1];
            lift_tab[n][k] = lift_tab[mid][k-1];
        end
    endfunction

    // edge count between two nodes through their lowest common ancestor
    function automatic bit [DIST_W-1:0] path_length(bit [NODE_W-1:0] x, bit [NODE_W-1:0] y);
        bit [NODE_W-1:0] a;
        bit [NODE_W-1:0] b;
        bit [NODE_W-1:0] c;
        bit [NODE_W-1:0] ua;
        bit [NODE_W-1:0] ub;
        longint d;
        a = x;
        b = y;
        if (depth_tab[a] < depth_tab[b])
        begin
            a = y;
            b = x;
        end
        // lift the deeper node to the depth of the other
        for (int k = LevelsDef - 1; k >= 0; k--)
        begin
            ua = lift_tab[a][k];
            if (depth_tab[ua] >= depth_tab[b])
                a = ua;
        end
        c = a;
        // lift both to just below the common ancestor
        if (a != b)
        begin
            for (int k = LevelsDef - 1; k >= 0; k--)
            begin
                ua = lift_tab[a][k];
                ub = lift_tab[b][k];
                if (ua != ub)
                begin
                    a = ua;
                    b = ub;
                end
                c = lift_tab[a][k];
            end
        end
        d = longint'(depth_tab[x]) + longint'(depth_tab[y]) - 2 * longint'(depth_tab[c]);
        if (d < 0)
            d = 0;
        if (d > 131070)
            d = 131070;
        return d[DIST_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic void queue_op(logic [FUNC_W-1:0] f, int unsigned n, int unsigned m);
        tree_op_t op;
        op.func       = f;
        op.node       = n[NODE_W-1:0];
        op.other_node = m[NODE_W-1:0];
        pending.insert(pending.size(), op);
    endfunction

    function automatic void queue_add(int unsigned n, int unsigned p);
        queue_op(FUNC_ADD, n, p);
        if (n != 0 && !in_tree[n])
        begin
            in_tree[n] = 1'b1;
            members.insert(members.size(), n);
        end
    endfunction

    function automatic int unsigned any_member();
        return members[$urandom_range(members.size() - 1)];
    endfunction

    // one of the newest nodes, so chains grow deep
    function automatic int unsigned recent_member();
        int unsigned span;
        span = (members.size() > 8) ? 7 : members.size() - 1;
        return members[members.size() - 1 - $urandom_range(span)];
    endfunction

    function automatic int unsigned fresh_node();
        int unsigned n;
        do
            n = $urandom_range(65535);
        while (n == 0 || in_tree[n]);
        return n;
    endfunction

    // idling phases follow progress through the stimulus
    function automatic int unsigned stim_phase();
        int unsigned ph;
        ph = (total_items == 0) ? 0 : (items_taken * 3) / total_items;
        return (ph > 2) ? 2 : ph;
    endfunction

    function automatic int unsigned sender_idle_pct();
        case (stim_phase())
            0:       return 27;
            1:       return 69;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_idle_pct();
        case (stim_phase())
            0:       return 69;
            1:       return 27;
            default: return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // driver: offers pending items, predicts each transfer as it lands
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : drive_items
        tree_op_t op;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.func == FUNC_QUERY)
                    distance_due.insert(distance_due.size(),
                                        path_length(item_ch.node, item_ch.other_node));
                else
                    graft_node(item_ch.node, item_ch.other_node);
                items_taken <= items_taken + 1;
            end
            // a held item stays put until its transfer
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    op = pending.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.func       <= op.func;
                    item_ch.node       <= op.node;
                    item_ch.other_node <= op.other_node;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each distance against the oldest prediction
    // and drives ready, including one long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        bit [DIST_W-1:0] want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (distance_due.size() == 0)
                begin
                    $error("distance transfer with nothing expected: actual %0d",
                           result_ch.distance);
                    fail_count++;
                end
                else
                begin
                    want = distance_due.pop_front();
                    if (result_ch.distance !== want)
                    begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               want, result_ch.distance);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stim_phase() == 2 && !long_hold_done)
            begin
                // sender never idles here, so the block backs up
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // cycles since the last transfer on either channel
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tree_distance_binary_lifting_tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin : main_flow
        int unsigned counted;
        int unsigned pick;
        int unsigned n;
        int unsigned m;

        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.func       = FUNC_ADD;
        item_ch.node       = '0;
        item_ch.other_node = '0;
        result_ch.ready    = 1'b0;

        in_tree[0] = 1'b1;
        members.insert(members.size(), 0);

        // directed: root alone, root re-add, extreme node numbers
        queue_op(FUNC_QUERY, 0, 0);
        queue_add(0, 0);
        queue_add(16'hFFFF, 0);
        queue_op(FUNC_QUERY, 16'hFFFF, 0);
        queue_op(FUNC_QUERY, 0, 16'hFFFF);
        // a chain under the top node and a short second branch
        queue_add(16'h8000, 16'hFFFF);
        queue_add(16'h7FFF, 16'h8000);
        queue_add(16'h5555, 16'h7FFF);
        queue_add(16'hAAAA, 16'h5555);
        queue_add(1, 0);
        queue_add(2, 1);
        queue_op(FUNC_QUERY, 16'hAAAA, 2);
        queue_op(FUNC_QUERY, 16'hAAAA, 16'h8000);
        queue_op(FUNC_QUERY, 16'hAAAA, 16'hAAAA);
        queue_op(FUNC_QUERY, 16'hFFFF, 16'hAAAA);
        // root under a non-root parent is dropped
        queue_add(0, 16'hAAAA);
        // re-parent a mid-chain node, leaving its descendants stale
        queue_add(16'h7FFF, 2);
        queue_op(FUNC_QUERY, 16'hAAAA, 2);
        // node made its own parent
        queue_add(1, 1);
        queue_op(FUNC_QUERY, 1, 2);
        queue_op(FUNC_QUERY, 1, 16'hAAAA);
        // node hung under its own descendant
        queue_add(16'hFFFF, 16'hAAAA);
        queue_op(FUNC_QUERY, 16'hFFFF, 16'h5555);

        // random: mostly a growing tree with queries, some broken adds
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                m = ($urandom_range(99) < 60) ? recent_member() : any_member();
                queue_add(fresh_node(), m);
                counted++;
            end
            else if (pick < 93)
            begin
                n = ($urandom_range(99) < 30) ? recent_member() : any_member();
                m = any_member();
                if ($urandom_range(1))
                    queue_op(FUNC_QUERY, n, m);
                else
                    queue_op(FUNC_QUERY, m, n);
                counted++;
            end
            else if (pick < 96)
            begin
                // re-add an existing node under some other node
                n = any_member();
                if (n != 0)
                begin
                    queue_add(n, any_member());
                    counted++;
                end
            end
            else if (pick < 98)
            begin
                n = any_member();
                if (n != 0)
                begin
                    queue_add(n, n);
                    counted++;
                end
            end
            else
            begin
                // ignored by the block, so not counted
                queue_add(0, any_member());
            end
        end
        total_items = pending.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items || distance_due.size() != 0)
            @(posedge clk);
        // any stray transfer here is caught by the monitor
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tree_distance_binary_lifting_tb: PASS");
        else
            $display("tree_distance_binary_lifting_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tdbl_pkg.sv
hw/rtl/tdbl_if.sv
hw/rtl/tree_distance_binary_lifting.sv
hw/rtl/tdbl_chk.sv
sim/tree_distance_binary_lifting_tb.sv
